// ===== design/smart_card_atr_parser_top_defines.svh =====
// Assertion macros used by the parser top, which checks itself.
// Each assertion samples on the rising edge of clk and is ignored while rst_n is low.
`ifndef SMART_CARD_ATR_PARSER_TOP_DEFINES_SVH
`define SMART_CARD_ATR_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCAP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/scap_pkg.sv =====
package scap_pkg;

    localparam int MAX_ATR_BYTES = 64;
    localparam logic [6:0] MAX_COUNT = 7'(MAX_ATR_BYTES);

    localparam logic [7:0] TS_DIRECT    = 8'h3B;
    localparam logic [7:0] TS_INVERSE   = 8'h3F;
    localparam logic [3:0] PROTO_NONE   = 4'd15;
    localparam logic [7:0] IFSC_DEFAULT = 8'd32;
    localparam logic [2:0] IFSC_GROUP   = 3'd3;
    localparam logic [2:0] GROUP_LIMIT  = 3'd7;

    typedef enum logic [2:0] {
        PH_TS    = 3'd0,
        PH_T0    = 3'd1,
        PH_IFACE = 3'd2,
        PH_HIST  = 3'd3,
        PH_TAIL  = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [6:0] count_seen;
        logic [3:0] y_nibble;
        logic [2:0] group_number;
        logic [3:0] history_left;
        logic       any_nonzero;
        logic       first_valid;
        logic [3:0] first_value;
        logic [1:0] mask_bits;
        logic [7:0] ifsc_value;
        logic [7:0] xor_sum;
        logic [6:0] body_length;
        logic       error_flag;
    } parse_state_t;

    typedef struct packed {
        logic       status;
        logic [3:0] first_protocol;
        logic [1:0] proto_mask;
        logic [7:0] card_ifsc;
        logic [6:0] atr_length;
        logic       tck_present;
        logic [7:0] tck_value;
    } atr_result_t;

    function automatic parse_state_t state_reset();
        parse_state_t s;
        s.phase        = PH_TS;
        s.count_seen   = 7'd0;
        s.y_nibble     = 4'd0;
        s.group_number = 3'd1;
        s.history_left = 4'd0;
        s.any_nonzero  = 1'b0;
        s.first_valid  = 1'b0;
        s.first_value  = 4'd0;
        s.mask_bits    = 2'd0;
        s.ifsc_value   = IFSC_DEFAULT;
        s.xor_sum      = 8'd0;
        s.body_length  = 7'd0;
        s.error_flag   = 1'b0;
        return s;
    endfunction

endpackage

// ===== design/scap_step.sv =====
module scap_step
    import scap_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   atr_byte,
    input  logic         last_byte,
    output parse_state_t nxt,
    output atr_result_t  result
);

    parse_state_t w;
    logic [3:0]   p;
    logic [6:0]   need;
    logic         bad;

    always_comb
    begin
        w = cur;
        p = atr_byte[3:0];
        if (cur.count_seen <= MAX_COUNT)
        begin
            w.count_seen = cur.count_seen + 7'd1;
        end
        if (w.count_seen <= MAX_COUNT)
        begin
            case (cur.phase)
                PH_TS:
                begin
                    w.body_length = 7'd1;
                    if (atr_byte != TS_DIRECT && atr_byte != TS_INVERSE)
                    begin
                        w.error_flag = 1'b1;
                        w.phase      = PH_TAIL;
                    end
                    else
                    begin
                        w.phase = PH_T0;
                    end
                end
                PH_T0:
                begin
                    w.body_length  = cur.body_length + 7'd1;
                    w.xor_sum      = cur.xor_sum ^ atr_byte;
                    w.y_nibble     = atr_byte[7:4];
                    w.history_left = atr_byte[3:0];
                    if (w.y_nibble != 4'd0)
                    begin
                        w.phase = PH_IFACE;
                    end
                    else
                    begin
                        w.phase = (w.history_left != 4'd0) ? PH_HIST : PH_TAIL;
                    end
                end
                PH_IFACE:
                begin
                    w.body_length = cur.body_length + 7'd1;
                    w.xor_sum     = cur.xor_sum ^ atr_byte;
                    if (cur.y_nibble[0])
                    begin
                        // TA of the third group carries the IFSC.
                        if (cur.group_number == IFSC_GROUP)
                        begin
                            w.ifsc_value = atr_byte;
                        end
                        w.y_nibble[0] = 1'b0;
                    end
                    else if (cur.y_nibble[1])
                    begin
                        w.y_nibble[1] = 1'b0;
                    end
                    else if (cur.y_nibble[2])
                    begin
                        w.y_nibble[2] = 1'b0;
                    end
                    else
                    begin
                        // TD word: protocol in the low nibble, next Y in the high one.
                        if (!cur.first_valid && p != PROTO_NONE)
                        begin
                            w.first_valid = 1'b1;
                            w.first_value = p;
                        end
                        if (p[3:1] == 3'd0)
                        begin
                            w.mask_bits[p[0]] = 1'b1;
                        end
                        if (p != 4'd0)
                        begin
                            w.any_nonzero = 1'b1;
                        end
                        w.y_nibble = atr_byte[7:4];
                        if (cur.group_number < GROUP_LIMIT)
                        begin
                            w.group_number = cur.group_number + 3'd1;
                        end
                    end
                    if (w.y_nibble == 4'd0)
                    begin
                        w.phase = (cur.history_left != 4'd0) ? PH_HIST : PH_TAIL;
                    end
                end
                PH_HIST:
                begin
                    w.body_length  = cur.body_length + 7'd1;
                    w.xor_sum      = cur.xor_sum ^ atr_byte;
                    w.history_left = cur.history_left - 4'd1;
                    if (w.history_left == 4'd0)
                    begin
                        w.phase = PH_TAIL;
                    end
                end
                default:
                begin
                end
            endcase
        end

        need = w.body_length + {6'd0, w.any_nonzero};
        bad  = (w.count_seen < 7'd2) || (w.count_seen > MAX_COUNT) || w.error_flag ||
               (w.phase != PH_TAIL) || (w.count_seen < need);

        result = '0;
        if (bad)
        begin
            result.status = 1'b1;
        end
        else
        begin
            result.first_protocol   = w.first_valid ? w.first_value : 4'd0;
            result.proto_mask       = w.mask_bits;
            if (!w.first_valid)
            begin
                result.proto_mask[0] = 1'b1;
            end
            result.card_ifsc        = w.ifsc_value;
            result.atr_length       = need;
            result.tck_present      = w.any_nonzero;
            result.tck_value        = w.any_nonzero ? w.xor_sum : 8'd0;
        end

        // The last word closes the ATR and leaves the parser ready for the next one.
        nxt = last_byte ? state_reset() : w;
    end

endmodule

// ===== design/smart_card_atr_parser_top.sv =====
// ATR parser: takes one answer-to-reset word per cycle, TS first, with last_byte on the
// final word, and sustains one word per cycle but for the hold-back below. A word passes an
// input register, then the combinational parse step updates the parse state; the result of
// the ATR is loaded into the output register at the same edge at which its last word leaves
// the input register, which raises out_valid. Input is held back only while a last word
// waits in the input register and the previous result has not yet been taken.
`include "smart_card_atr_parser_top_defines.svh"

module smart_card_atr_parser_top
    import scap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] atr_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       status,
    output logic [3:0] first_protocol,
    output logic [1:0] proto_mask,
    output logic [7:0] card_ifsc,
    output logic [6:0] atr_length,
    output logic       tck_present,
    output logic [7:0] tck_value
);

    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic         s1_last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    atr_result_t  result_next;
    atr_result_t  out_reg;
    logic         out_valid_reg;
    logic         out_free;
    logic         advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || advance;

    scap_step u_step
    (
        .cur       (state_reg),
        .atr_byte  (s1_byte_reg),
        .last_byte (s1_last_reg),
        .nxt       (state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            state_reg     <= state_reset();
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= atr_byte;
            s1_last_reg <= last_byte;
        end
        if (advance && s1_last_reg)
        begin
            out_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign first_protocol = out_reg.first_protocol;
    assign proto_mask     = out_reg.proto_mask;
    assign card_ifsc      = out_reg.card_ifsc;
    assign atr_length     = out_reg.atr_length;
    assign tck_present    = out_reg.tck_present;
    assign tck_value      = out_reg.tck_value;

    // A word in the input register stalls only when it closes an ATR and the result is blocked.
    `SCAP_ASSERT_SAME(a_stall_cause, s1_valid_reg && !advance,
        s1_last_reg && out_valid_reg && !out_ready, "input stage stalled without cause")
    // A frame error carries no other information.
    `SCAP_ASSERT_SAME(a_error_clean, out_valid_reg && out_reg.status,
        out_reg.first_protocol == 4'd0 && out_reg.proto_mask == 2'd0 &&
        out_reg.card_ifsc == 8'd0 && out_reg.atr_length == 7'd0 &&
        out_reg.tck_present == 1'b0 && out_reg.tck_value == 8'd0,
        "frame error result has nonzero fields")
    // A good ATR always fits the length limit and holds at least TS and T0.
    `SCAP_ASSERT_SAME(a_good_result, out_valid_reg && !out_reg.status,
        out_reg.atr_length >= 7'd2 && out_reg.atr_length <= MAX_COUNT,
        "good result out of range")
    // Closing an ATR returns the parser to its reset state.
    `SCAP_ASSERT_NEXT(a_state_cleared, advance && s1_last_reg,
        state_reg == state_reset(), "parse state not cleared after last word")

endmodule

// ===== bench/smart_card_atr_parser_top_tb.sv =====
module smart_card_atr_parser_top_tb;
    import scap_pkg::*;

    typedef enum logic [1:0] {
        PACE_SLOW_RX,
        PACE_SLOW_TX,
        PACE_FULL
    } pace_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        pace_t      pace;
        logic       sync;
        logic       hold;
    } word_t;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_WORDS  = 1550;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] atr_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       status;
    logic [3:0] first_protocol;
    logic [1:0] proto_mask;
    logic [7:0] card_ifsc;
    logic [6:0] atr_length;
    logic       tck_present;
    logic [7:0] tck_value;

    logic        hold_req = 1'b0;
    int          rx_hold = 0;
    pace_t       rx_pace = PACE_SLOW_RX;
    int          mismatch_count = 0;
    int          results_seen = 0;

    word_t       pending_words[$];
    atr_result_t pending_results[$];
    logic [7:0]  atr_buf[$];
    parse_state_t atr_st;

    smart_card_atr_parser_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .atr_byte       (atr_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .first_protocol (first_protocol),
        .proto_mask     (proto_mask),
        .card_ifsc      (card_ifsc),
        .atr_length     (atr_length),
        .tck_present    (tck_present),
        .tck_value      (tck_value)
    );

    function automatic int tx_idle_pct(pace_t p);
        case (p)
            PACE_SLOW_RX: return 25;
            PACE_SLOW_TX: return 64;
            default:      return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(pace_t p);
        case (p)
            PACE_SLOW_RX: return 64;
            PACE_SLOW_TX: return 25;
            default:      return 0;
        endcase
    endfunction

    task automatic restart_parse();
        atr_st.phase        = PH_TS;
        atr_st.count_seen   = 7'd0;
        atr_st.y_nibble     = 4'd0;
        atr_st.group_number = 3'd1;
        atr_st.history_left = 4'd0;
        atr_st.any_nonzero  = 1'b0;
        atr_st.first_valid  = 1'b0;
        atr_st.first_value  = 4'd0;
        atr_st.mask_bits    = 2'd0;
        atr_st.ifsc_value   = IFSC_DEFAULT;
        atr_st.xor_sum      = 8'd0;
        atr_st.body_length  = 7'd0;
        atr_st.error_flag   = 1'b0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [3:0] p;
        case (atr_st.phase)
            PH_TS: begin
                atr_st.body_length = 7'd1;
                if (b != TS_DIRECT && b != TS_INVERSE) begin
                    atr_st.error_flag = 1'b1;
                    atr_st.phase = PH_TAIL;
                end else begin
                    atr_st.phase = PH_T0;
                end
            end
            PH_T0: begin
                atr_st.body_length = atr_st.body_length + 7'd1;
                atr_st.xor_sum = atr_st.xor_sum ^ b;
                atr_st.y_nibble = b[7:4];
                atr_st.history_left = b[3:0];
                if (atr_st.y_nibble != 4'd0)
                    atr_st.phase = PH_IFACE;
                else
                    atr_st.phase = (atr_st.history_left != 4'd0) ? PH_HIST : PH_TAIL;
            end
            PH_IFACE: begin
                atr_st.body_length = atr_st.body_length + 7'd1;
                atr_st.xor_sum = atr_st.xor_sum ^ b;
                // Interface bytes come in TA, TB, TC, TD order within a group.
                if (atr_st.y_nibble[0]) begin
                    if (atr_st.group_number == IFSC_GROUP)
                        atr_st.ifsc_value = b;
                    atr_st.y_nibble[0] = 1'b0;
                end else if (atr_st.y_nibble[1]) begin
                    atr_st.y_nibble[1] = 1'b0;
                end else if (atr_st.y_nibble[2]) begin
                    atr_st.y_nibble[2] = 1'b0;
                end else begin
                    p = b[3:0];
                    if (!atr_st.first_valid && p != PROTO_NONE) begin
                        atr_st.first_valid = 1'b1;
                        atr_st.first_value = p;
                    end
                    if (p < 4'd2)
                        atr_st.mask_bits[p[0]] = 1'b1;
                    if (p != 4'd0)
                        atr_st.any_nonzero = 1'b1;
                    atr_st.y_nibble = b[7:4];
                    if (atr_st.group_number < GROUP_LIMIT)
                        atr_st.group_number = atr_st.group_number + 3'd1;
                end
                if (atr_st.y_nibble == 4'd0)
                    atr_st.phase = (atr_st.history_left != 4'd0) ? PH_HIST : PH_TAIL;
            end
            PH_HIST: begin
                atr_st.body_length = atr_st.body_length + 7'd1;
                atr_st.xor_sum = atr_st.xor_sum ^ b;
                atr_st.history_left = atr_st.history_left - 4'd1;
                if (atr_st.history_left == 4'd0)
                    atr_st.phase = PH_TAIL;
            end
            default: ;
        endcase
    endtask

    task automatic parse_atr_word(input logic [7:0] b, input logic fin);
        atr_result_t r;
        int need;
        if (atr_st.count_seen <= MAX_COUNT)
            atr_st.count_seen = atr_st.count_seen + 7'd1;
        if (atr_st.count_seen <= MAX_COUNT)
            parse_byte(b);
        if (fin) begin
            need = int'(atr_st.body_length) + int'(atr_st.any_nonzero);
            r = '0;
            if (atr_st.count_seen < 7'd2 || atr_st.count_seen > MAX_COUNT ||
                atr_st.error_flag || atr_st.phase != PH_TAIL ||
                int'(atr_st.count_seen) < need) begin
                r.status = 1'b1;
            end else begin
                r.first_protocol = atr_st.first_valid ? atr_st.first_value : 4'd0;
                r.proto_mask     = atr_st.mask_bits | {1'b0, !atr_st.first_valid};
                r.card_ifsc      = atr_st.ifsc_value;
                r.atr_length     = 7'(need);
                r.tck_present    = atr_st.any_nonzero;
                r.tck_value      = atr_st.any_nonzero ? atr_st.xor_sum : 8'd0;
            end
            pending_results.push_back(r);
            restart_parse();
        end
    endtask

    task automatic note_error(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_error($sformatf("result %0d %s: got %0d, expected %0d",
                                 results_seen, name, got, want));
    endtask

    // Builds an ATR with random content into atr_buf, well-formed but now and then missing its TCK.
    task automatic build_well();
        logic [3:0] y;
        logic [3:0] k;
        logic [3:0] ny;
        logic [3:0] p;
        int grp;
        logic tck_due;
        atr_buf.delete();
        atr_buf.push_back($urandom_range(0, 1) ? TS_DIRECT : TS_INVERSE);
        k = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
        y = 4'($urandom);
        atr_buf.push_back({y, k});
        grp = 1;
        tck_due = 1'b0;
        while (y != 4'd0) begin
            if (y[0]) atr_buf.push_back(8'($urandom));
            if (y[1]) atr_buf.push_back(8'($urandom));
            if (y[2]) atr_buf.push_back(8'($urandom));
            if (y[3]) begin
                case ($urandom_range(0, 5))
                    0, 1:    p = 4'd0;
                    2, 3:    p = 4'd1;
                    4:       p = PROTO_NONE;
                    default: p = 4'($urandom);
                endcase
                // Mostly short chains; now and then one long enough to saturate the group count.
                ny = (grp < 4 || ($urandom_range(0, 3) == 0 && grp < 9)) ? 4'($urandom) : 4'd0;
                atr_buf.push_back({ny, p});
                if (p != 4'd0)
                    tck_due = 1'b1;
                y = ny;
                grp++;
            end else begin
                y = 4'd0;
            end
        end
        repeat (k) atr_buf.push_back(8'($urandom));
        if (tck_due && $urandom_range(0, 19) != 0)
            atr_buf.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) atr_buf.push_back(8'($urandom));
    endtask

    task automatic push_atr(input pace_t pace, input logic sync, input logic hold);
        word_t w;
        foreach (atr_buf[i]) begin
            w.data = atr_buf[i];
            w.fin  = (i == atr_buf.size() - 1);
            w.pace = pace;
            w.sync = sync && (i == 0);
            w.hold = hold && (i == 0);
            pending_words.push_back(w);
        end
    endtask

    initial begin : clock_gen
        forever #10 clk = ~clk;
    end

    initial begin : reset_gen
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin : watchdog
        #4000000;
        $display("timeout waiting for the parser to drain");
        $display("smart_card_atr_parser_top_tb failed");
        $finish;
    end

    always @(posedge clk) begin : drive_words
        logic  taken;
        logic  offer;
        logic  hold_next;
        word_t head;
        taken = in_valid && in_ready;
        hold_next = 1'b0;
        if (taken) begin
            head = pending_words.pop_front();
            parse_atr_word(head.data, head.fin);
            hold_next = head.hold;
            rx_pace <= head.pace;
        end
        if (rst_n && (!in_valid || taken)) begin
            offer = 1'b0;
            if (pending_words.size() != 0) begin
                head = pending_words[0];
                // A sync word waits until every result so far has been taken.
                offer = !(head.sync && pending_results.size() != 0) &&
                        ($urandom_range(0, 99) >= tx_idle_pct(head.pace));
            end
            in_valid <= offer;
            if (offer) begin
                atr_byte  <= head.data;
                last_byte <= head.fin;
            end
        end
        hold_req <= hold_next;
    end

    always @(posedge clk) begin : rx_holdoff
        if (hold_req)
            rx_hold <= HOLD_CYCLES;
        else if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
    end

    always @(posedge clk) begin : check_results
        atr_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("result with none expected, status %0d", status));
            end else begin
                want = pending_results.pop_front();
                check_field("status", status, want.status);
                check_field("first_protocol", first_protocol, want.first_protocol);
                check_field("proto_mask", proto_mask, want.proto_mask);
                check_field("card_ifsc", card_ifsc, want.card_ifsc);
                check_field("atr_length", atr_length, want.atr_length);
                check_field("tck_present", tck_present, want.tck_present);
                check_field("tck_value", tck_value, want.tck_value);
            end
            results_seen++;
        end
        out_ready <= (rx_hold == 0) && ($urandom_range(0, 99) >= rx_idle_pct(rx_pace));
    end

    initial begin : stimulus
        int total;
        int atr_count;
        int r;
        int cut;
        int n;
        logic [7:0] b;
        pace_t pace;
        pace_t prev_pace;
        restart_parse();

        // Shortest good ATR, a lone TS, and a bad TS followed by ignored words.
        atr_buf = '{TS_DIRECT, 8'h00};
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        atr_buf = '{TS_INVERSE};
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        atr_buf = '{8'h00, 8'hFF, 8'h3B};
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        // All four interface bytes in two groups, protocol 15 skipped, IFSC from TA3.
        atr_buf = '{TS_INVERSE, 8'hF0, 8'h11, 8'h22, 8'h33, 8'hF1, 8'h44, 8'h55, 8'h66,
                    8'h1F, 8'hFE, 8'h00};
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        // Long TD chain ending with protocol 14.
        atr_buf.delete();
        atr_buf.push_back(TS_DIRECT);
        repeat (9) atr_buf.push_back(8'h80);
        atr_buf.push_back(8'h0E);
        atr_buf.push_back(8'hAA);
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        // Only protocol 15 offered, fifteen historical bytes.
        atr_buf.delete();
        atr_buf.push_back(TS_DIRECT);
        atr_buf.push_back(8'h8F);
        atr_buf.push_back(8'h0F);
        repeat (15) atr_buf.push_back(8'hFF);
        atr_buf.push_back(8'h00);
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        // Truncated in the historical bytes, missing TCK, and trailing words.
        atr_buf = '{TS_DIRECT, 8'h15, 8'h96, 8'h01};
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        atr_buf = '{TS_DIRECT, 8'h80, 8'h01};
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        atr_buf = '{TS_DIRECT, 8'h00, 8'hAA, 8'h55};
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        // Exactly the maximum length, then one word over it, then far over it.
        atr_buf.delete();
        atr_buf.push_back(TS_DIRECT);
        atr_buf.push_back(8'h8F);
        repeat (45) atr_buf.push_back(8'h81);
        atr_buf.push_back(8'h01);
        repeat (15) atr_buf.push_back(8'h5A);
        atr_buf.push_back(8'hC3);
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        atr_buf.push_back(8'h00);
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);
        atr_buf.delete();
        atr_buf.push_back(TS_DIRECT);
        repeat (69) atr_buf.push_back(8'hFF);
        push_atr(PACE_SLOW_RX, 1'b0, 1'b0);

        total = 0;
        atr_count = 0;
        prev_pace = PACE_SLOW_RX;
        while (total < RANDOM_WORDS) begin
            if (total < RANDOM_WORDS / 3)
                pace = PACE_SLOW_RX;
            else if (total < 2 * RANDOM_WORDS / 3)
                pace = PACE_SLOW_TX;
            else
                pace = PACE_FULL;
            r = $urandom_range(0, 99);
            if (r < 78) begin
                build_well();
            end else if (r < 88) begin
                build_well();
                cut = $urandom_range(1, atr_buf.size() - 1);
                while (atr_buf.size() > cut)
                    void'(atr_buf.pop_back());
            end else if (r < 93) begin
                atr_buf.delete();
                do
                    b = 8'($urandom);
                while (b == TS_DIRECT || b == TS_INVERSE);
                atr_buf.push_back(b);
                repeat ($urandom_range(0, 10)) atr_buf.push_back(8'($urandom));
            end else if (r < 97) begin
                atr_buf.delete();
                repeat ($urandom_range(1, 20)) atr_buf.push_back(8'($urandom));
            end else begin
                build_well();
                n = $urandom_range(65, 72);
                while (atr_buf.size() < n)
                    atr_buf.push_back(8'($urandom));
            end
            push_atr(pace, (pace != prev_pace) || (atr_count % 50 == 0),
                     (atr_count % 50 == 25) && (pace != PACE_SLOW_TX));
            total += atr_buf.size();
            atr_count++;
            prev_pace = pace;
        end

        @(posedge clk);
        while (!rst_n || pending_words.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("smart_card_atr_parser_top_tb passed");
        else
            $display("smart_card_atr_parser_top_tb failed");
        $finish;
    end

endmodule
